>>> design/psma_pkg.sv
// Shared types and constants of the per-sensor moving average alarm.
// Used by psma_ctrl, psma_dpath, the top level and the port checker.
package psma_pkg;

   localparam int WINDOW      = 5;
   localparam int MAX_SENSORS = 16;

   localparam int IDX_W     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int CNT_W     = $clog2(MAX_SENSORS + 1);
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int MEM_DEPTH = MAX_SENSORS * WINDOW;
   localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int SUM_W     = 18;   // 8 * 32767 fits
   localparam int DCNT_W    = 5;    // divider step counter, up to SUM_W - 1

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNKNOWN = 3'd1,
      ST_INVALID = 3'd2,
      ST_STORED  = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      REG_MAX_TEMP = 1'b0,
      REG_MIN_TEMP = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      MODE_LOAD   = 1'b0,
      MODE_SAMPLE = 1'b1
   } mode_type;

   typedef struct packed {
      logic idle;
      logic load_entry;
      logic set_first;
      logic scan_next;
      logic upd_start;
      logic slot_read;
      logic slot_shift;
      logic slot_last;
      logic div_step;
      logic commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic scan_end;
      logic match;
      logic val_pos;
      logic slot_is_last;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

>>> design/per_sensor_moving_average_alarm.sv
// Top level of the per-sensor moving average alarm.
// Depends on psma_pkg, psma_ctrl and psma_dpath.
//
// Usage:
//   req_* carries one item: tuser is the mode (0 load a sensor/room entry,
//   1 deliver a sample). A load appends an entry to the sensor table; a sample
//   is matched by sensor ID against every loaded entry, and each match with a
//   positive value shifts the sample into that entry's window and recomputes
//   the average. rsp_* returns one item per request; tuser is the status code.
//   csr_* writes max_temp (index 0) and min_temp (index 1); the user writes them
//   only while idle, which the block does not enforce.
// Timing:
//   A load goes through LOAD and FIN. A sample goes through LOAD, then SCAN
//   visits each table entry; each match with a positive value is updated: the
//   window shift runs through a single-port window memory, each slot read in UPD
//   and written in SHF, then an 18-step bit-serial divide forms the average.
//   One item is in work at a time; req_tready is high only when idle.
// Reset clears the entry count and control state and sets the thresholds to 6400 and 2560.
// When rsp_tready is low the result waits in the output register; the next
// request is still taken, and its result waits for the register to drain.
module per_sensor_moving_average_alarm (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [psma_pkg::REQ_DATA_W-1:0] req_tdata,   // node_id, room_id, sample_value,
                                                        // sample_time
   input  logic [0:0]                      req_tuser,   // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [psma_pkg::RSP_DATA_W-1:0] rsp_tdata,   // room_of_sensor, window_average,
                                                        // samples_held, too_hot, too_cold,
                                                        // last_update_time, zero pad
   output logic [2:0]                      rsp_tuser,   // status
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [15:0]                     csr_wdata
);

   psma_pkg::cmd_type    cmd;
   psma_pkg::stat_type   stat;
   psma_pkg::status_type status;
   logic [15:0]          room;
   logic [14:0]          avg;
   logic [3:0]           held;
   logic                 hot, cold;
   logic [31:0]          tstamp;

   psma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .stat       (stat),
      .cmd        (cmd)
   );

   psma_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_tvalid      (req_tvalid),
      .in_mode         (req_tuser[0]),
      .in_node_id      (req_tdata[15:0]),
      .in_room_id      (req_tdata[31:16]),
      .in_sample_value (req_tdata[47:32]),
      .in_sample_time  (req_tdata[79:48]),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (status),
      .rsp_room        (room),
      .rsp_avg         (avg),
      .rsp_held        (held),
      .rsp_hot         (hot),
      .rsp_cold        (cold),
      .rsp_time        (tstamp)
   );

   assign req_tready = cmd.idle;
   assign rsp_tuser  = status;
   assign rsp_tdata  = {3'b000, tstamp, cold, hot, held, avg, room};

endmodule

>>> design/psma_ctrl.sv
// Controller state machine of the per-sensor moving average alarm.
// Depends on psma_pkg; drives psma_dpath through cmd_type only.
module psma_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  psma_pkg::stat_type stat,
   output psma_pkg::cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LOAD   = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_UPD    = 8'b0000_1000,
      S_SHF    = 8'b0001_0000,
      S_DIV    = 8'b0010_0000,
      S_COMMIT = 8'b0100_0000,
      S_FIN    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (req_tvalid) begin
               state_in = S_LOAD;   // mode is latched this edge; LOAD forks on it
            end
         end
         S_LOAD: begin
            if (stat.is_load) begin
               cmd.load_entry = 1'b1;
               state_in       = S_FIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_FIN;
            end else if (stat.match) begin
               cmd.set_first = 1'b1;
               if (stat.val_pos) begin
                  cmd.upd_start = 1'b1;
                  state_in      = S_UPD;
               end else begin
                  cmd.scan_next = 1'b1;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_UPD: begin
            if (stat.slot_is_last) begin
               cmd.slot_last = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.slot_read = 1'b1;
               state_in      = S_SHF;
            end
         end
         S_SHF: begin
            cmd.slot_shift = 1'b1;
            state_in       = S_UPD;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit    = 1'b1;
            cmd.scan_next = 1'b1;
            state_in      = S_SCAN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/psma_dpath.sv
// Datapath: sensor tables, window memory, divider, thresholds and result register.
// Depends on psma_pkg; controlled by psma_ctrl.
module psma_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  psma_pkg::cmd_type    cmd,
   output psma_pkg::stat_type   stat,
   input  logic                 req_tvalid,
   input  logic                 in_mode,
   input  logic [15:0]          in_node_id,
   input  logic [15:0]          in_room_id,
   input  logic signed [15:0]   in_sample_value,
   input  logic [31:0]          in_sample_time,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output psma_pkg::status_type rsp_status,
   output logic [15:0]          rsp_room,
   output logic [14:0]          rsp_avg,
   output logic [3:0]           rsp_held,
   output logic                 rsp_hot,
   output logic                 rsp_cold,
   output logic [31:0]          rsp_time
);

   localparam int IW = psma_pkg::IDX_W;
   localparam int CW = psma_pkg::CNT_W;
   localparam int SW = psma_pkg::SLOT_W;
   localparam int AW = psma_pkg::MEM_AW;
   localparam int UW = psma_pkg::SUM_W;

   // configuration
   logic signed [15:0] max_temp_ff, min_temp_ff;

   // latched item
   logic               mode_ff;
   logic [15:0]        sid_ff, rid_ff;
   logic signed [15:0] val_ff;
   logic [31:0]        ts_ff;

   // tables
   logic [CW-1:0] entry_count_ff;
   logic [15:0]   id_tab_ff   [psma_pkg::MAX_SENSORS];
   logic [15:0]   room_tab_ff [psma_pkg::MAX_SENSORS];
   logic [3:0]    cnt_tab_ff  [psma_pkg::MAX_SENSORS];
   logic [14:0]   avg_tab_ff  [psma_pkg::MAX_SENSORS];
   logic [31:0]   time_tab_ff [psma_pkg::MAX_SENSORS];
   logic          load_ok_ff;

   // scan
   logic [CW-1:0] idx_ff;
   logic          found_ff;
   logic [IW-1:0] first_ff;
   logic [IW-1:0] cur;

   // window update
   logic [14:0]   win_mem [psma_pkg::MEM_DEPTH];
   logic [14:0]   win_rd_ff;
   logic [SW-1:0] slot_ff;
   logic [UW-1:0] sum_ff;
   logic [AW-1:0] base;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [14:0]   mem_wd;
   logic [3:0]    cur_cnt, new_cnt;
   logic [UW-1:0] sum_last;

   // divider
   logic [UW-1:0]                 quot_ff;
   logic [3:0]                    rem_ff, dvs_ff;
   logic [psma_pkg::DCNT_W-1:0]   dcnt_ff;
   logic [4:0]                    rem_sh, rem_sub;
   logic                          qbit;

   logic val_pos, full;

   assign cur     = idx_ff[IW-1:0];
   assign val_pos = !val_ff[15] && (val_ff != 16'sd0);
   assign full    = (entry_count_ff == CW'(psma_pkg::MAX_SENSORS));
   assign base    = AW'(cur) * AW'(psma_pkg::WINDOW);
   assign cur_cnt = cnt_tab_ff[cur];
   assign new_cnt = (cur_cnt < 4'(psma_pkg::WINDOW)) ? cur_cnt + 4'd1
                                                     : 4'(psma_pkg::WINDOW);
   assign sum_last = sum_ff + UW'(val_ff[14:0]);

   assign stat.is_load      = (mode_ff == psma_pkg::MODE_LOAD);
   assign stat.scan_end     = (idx_ff >= entry_count_ff);
   assign stat.match        = (id_tab_ff[cur] == sid_ff);
   assign stat.val_pos      = val_pos;
   assign stat.slot_is_last = (slot_ff == SW'(psma_pkg::WINDOW - 1));
   assign stat.div_done     = (dcnt_ff == psma_pkg::DCNT_W'(UW - 1));
   assign stat.out_free     = !rsp_valid || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_temp_ff <= 16'sd6400;
         min_temp_ff <= 16'sd2560;
      end else if (csr_we) begin
         case (csr_index)
            psma_pkg::REG_MAX_TEMP: max_temp_ff <= csr_wdata;
            psma_pkg::REG_MIN_TEMP: min_temp_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idle && req_tvalid) begin
         mode_ff <= in_mode;
         sid_ff  <= in_node_id;
         rid_ff  <= in_room_id;
         val_ff  <= in_sample_value;
         ts_ff   <= in_sample_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         idx_ff         <= '0;
         found_ff       <= 1'b0;
      end else begin
         if (cmd.idle && req_tvalid) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.scan_next) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.set_first && !found_ff) begin
            found_ff <= 1'b1;
         end
         if (cmd.load_entry && !full) begin
            entry_count_ff <= entry_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_first && !found_ff) begin
         first_ff <= cur;
      end
      if (cmd.load_entry) begin
         load_ok_ff <= !full;
         if (!full) begin
            id_tab_ff[entry_count_ff[IW-1:0]]   <= sid_ff;
            room_tab_ff[entry_count_ff[IW-1:0]] <= rid_ff;
            cnt_tab_ff[entry_count_ff[IW-1:0]]  <= 4'd0;
            avg_tab_ff[entry_count_ff[IW-1:0]]  <= 15'd0;
            time_tab_ff[entry_count_ff[IW-1:0]] <= 32'd0;
         end
      end
      if (cmd.commit) begin
         cnt_tab_ff[cur]  <= dvs_ff;
         avg_tab_ff[cur]  <= quot_ff[14:0];
         time_tab_ff[cur] <= ts_ff;
      end
   end

   // Window shift: slot j takes old slot j+1; old slot counts toward the sum only if it was
   // within the valid tail of the window.
   always_comb begin
      mem_we = cmd.slot_shift || cmd.slot_last;
      if (cmd.slot_last) begin
         mem_wa = base + AW'(psma_pkg::WINDOW - 1);
         mem_wd = val_ff[14:0];
      end else begin
         mem_wa = base + AW'(slot_ff);
         mem_wd = win_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[mem_wa] <= mem_wd;
      end
      if (cmd.slot_read) begin
         win_rd_ff <= win_mem[base + AW'(slot_ff) + AW'(1)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd_start) begin
         slot_ff <= '0;
         sum_ff  <= '0;
      end
      if (cmd.slot_shift) begin
         slot_ff <= slot_ff + SW'(1);
         if ((5'(slot_ff) + 5'd1 + 5'(cur_cnt)) >= 5'(psma_pkg::WINDOW)) begin
            sum_ff <= sum_ff + UW'(win_rd_ff);
         end
      end
   end

   // Restoring divider, one quotient bit per cycle.
   assign rem_sh  = {rem_ff, quot_ff[UW-1]};
   assign qbit    = (rem_sh >= {1'b0, dvs_ff});
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.slot_last) begin
         quot_ff <= sum_last;
         rem_ff  <= 4'd0;
         dvs_ff  <= new_cnt;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[UW-2:0], qbit};
         rem_ff  <= qbit ? rem_sub[3:0] : rem_sh[3:0];
         dcnt_ff <= dcnt_ff + psma_pkg::DCNT_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_room <= 16'd0;
         rsp_avg  <= 15'd0;
         rsp_held <= 4'd0;
         rsp_hot  <= 1'b0;
         rsp_cold <= 1'b0;
         rsp_time <= 32'd0;
         if (mode_ff == psma_pkg::MODE_LOAD) begin
            if (load_ok_ff) begin
               rsp_status <= psma_pkg::ST_STORED;
               rsp_room   <= rid_ff;
            end else begin
               rsp_status <= psma_pkg::ST_FULL;
            end
         end else if (!found_ff) begin
            rsp_status <= psma_pkg::ST_UNKNOWN;
         end else begin
            rsp_room <= room_tab_ff[first_ff];
            rsp_avg  <= avg_tab_ff[first_ff];
            rsp_held <= cnt_tab_ff[first_ff];
            rsp_time <= time_tab_ff[first_ff];
            if (val_pos) begin
               rsp_status <= psma_pkg::ST_OK;
               rsp_hot    <= ($signed({1'b0, avg_tab_ff[first_ff]}) >= max_temp_ff);
               rsp_cold   <= ($signed({1'b0, avg_tab_ff[first_ff]}) < min_temp_ff);
            end else begin
               rsp_status <= psma_pkg::ST_INVALID;
            end
         end
      end
   end

endmodule

>>> design/psma_port_checker.sv
// Port-level checker of the per-sensor moving average alarm, bound to the top level.
// Depends on psma_pkg.
module psma_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == psma_pkg::ST_UNKNOWN || rsp_tuser == psma_pkg::ST_FULL)
      |-> rsp_tdata == 72'd0)
      else $error("unknown or full result carries data");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:31] <= 4'(psma_pkg::WINDOW))
      else $error("sample count beyond window");

   a_flags_ok_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != psma_pkg::ST_OK |-> rsp_tdata[36:35] == 2'b00)
      else $error("alarm flag on a non-accepted item");

endmodule

bind per_sensor_moving_average_alarm psma_port_checker u_psma_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/sv/per_sensor_moving_average_alarm_tb.sv
// Testbench for per_sensor_moving_average_alarm: predicts each result from its own
// sensor table and window model and checks it against the rsp stream.
// Depends on psma_pkg and the per_sensor_moving_average_alarm RTL.
module per_sensor_moving_average_alarm_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      psma_pkg::mode_type mode;
      logic [15:0]        node_id;
      logic [15:0]        room_id;
      logic [15:0]        sample_value;
      logic [31:0]        sample_time;
   } reading_type;

   typedef struct {
      psma_pkg::status_type status;
      logic [15:0]          room;
      logic [14:0]          average;
      logic [3:0]           held;
      logic                 hot;
      logic                 cold;
      logic [31:0]          stamp;
   } report_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_we;
   logic [0:0]   csr_index;
   logic [15:0]  csr_wdata;

   per_sensor_moving_average_alarm i_dut (.*);

   // sensor table model
   int unsigned entries;
   logic [15:0] ids[psma_pkg::MAX_SENSORS];
   logic [15:0] rooms[psma_pkg::MAX_SENSORS];
   logic [14:0] windows[psma_pkg::MAX_SENSORS][psma_pkg::WINDOW];
   int unsigned counts[psma_pkg::MAX_SENSORS];
   logic [14:0] averages[psma_pkg::MAX_SENSORS];
   logic [31:0] stamps[psma_pkg::MAX_SENSORS];
   int          hot_limit;
   int          cold_limit;

   reading_type pending_readings[$];
   report_type  expected_reports[$];
   logic [15:0] known_ids[$];
   int          mismatches;
   int          quiet_cycles;
   int          req_gap;
   int          rsp_stall;
   bit          req_taken;
   bit          no_idle;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic report_type predict_report(reading_type r);
      report_type rep;
      int         val;
      int         first;
      int unsigned sum;
      rep = '{psma_pkg::ST_OK, '0, '0, '0, 1'b0, 1'b0, '0};
      val = $signed(r.sample_value);
      first = -1;
      if (r.mode == psma_pkg::MODE_LOAD) begin
         if (entries >= psma_pkg::MAX_SENSORS) begin
            rep.status = psma_pkg::ST_FULL;
            return rep;
         end
         ids[entries] = r.node_id;
         rooms[entries] = r.room_id;
         for (int j = 0; j < psma_pkg::WINDOW; j++) windows[entries][j] = '0;
         counts[entries] = 0;
         averages[entries] = '0;
         stamps[entries] = '0;
         entries++;
         rep.status = psma_pkg::ST_STORED;
         rep.room = r.room_id;
         return rep;
      end
      // every matching entry is updated when the value is positive; the first one is reported
      for (int e = 0; e < entries; e++) begin
         if (ids[e] == r.node_id) begin
            if (first < 0) first = e;
            if (val > 0) begin
               for (int j = 0; j < psma_pkg::WINDOW - 1; j++)
                  windows[e][j] = windows[e][j+1];
               windows[e][psma_pkg::WINDOW-1] = val[14:0];
               if (counts[e] < psma_pkg::WINDOW) counts[e]++;
               sum = 0;
               for (int j = 0; j < psma_pkg::WINDOW; j++) sum += windows[e][j];
               averages[e] = 15'(sum / counts[e]);
               stamps[e] = r.sample_time;
            end
         end
      end
      if (first < 0) begin
         rep.status = psma_pkg::ST_UNKNOWN;
         return rep;
      end
      rep.room = rooms[first];
      rep.average = averages[first];
      rep.held = 4'(counts[first]);
      rep.stamp = stamps[first];
      if (val <= 0) begin
         rep.status = psma_pkg::ST_INVALID;
         return rep;
      end
      rep.hot = (int'(averages[first]) >= hot_limit);
      rep.cold = (int'(averages[first]) < cold_limit);
      return rep;
   endfunction

   // request driver and result back-pressure
   always @(negedge clock) begin
      logic        next_valid;
      reading_type r;
      if (!reset) begin
         next_valid = req_tvalid;
         if (req_taken) begin
            next_valid = 1'b0;
            req_taken = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_readings.size() > 0) begin
               r = pending_readings.pop_front();
               req_tdata <= {r.sample_time, r.sample_value, r.room_id, r.node_id};
               req_tuser <= r.mode;
               next_valid = 1'b1;
               req_gap = no_idle ? 0 : $urandom_range(0, 9);
            end
         end
         req_tvalid <= next_valid;
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: predicts on request accept, checks on result accept
   always @(posedge clock) begin
      reading_type r;
      report_type  want;
      report_type  got;
      if (!reset) begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            r.node_id = req_tdata[15:0];
            r.room_id = req_tdata[31:16];
            r.sample_value = req_tdata[47:32];
            r.sample_time = req_tdata[79:48];
            r.mode = psma_pkg::mode_type'(req_tuser);
            expected_reports.push_back(predict_report(r));
            req_taken = 1'b1;
            quiet_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            rsp_stall = no_idle ? 0 : $urandom_range(0, 9);
            got.status = psma_pkg::status_type'(rsp_tuser);
            got.room = rsp_tdata[15:0];
            got.average = rsp_tdata[30:16];
            got.held = rsp_tdata[34:31];
            got.hot = rsp_tdata[35];
            got.cold = rsp_tdata[36];
            got.stamp = rsp_tdata[68:37];
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item: status %0d", rsp_tuser);
            end else begin
               want = expected_reports.pop_front();
               if (got.status !== want.status || got.room !== want.room
                   || got.average !== want.average || got.held !== want.held
                   || got.hot !== want.hot || got.cold !== want.cold
                   || got.stamp !== want.stamp) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st=%0d room=%h avg=%h n=%0d hot=%b cold=%b t=%h",
                              want.status, want.room, want.average, want.held, want.hot,
                              want.cold, want.stamp,
                              "\n          got st=%0d room=%h avg=%h n=%0d hot=%b cold=%b t=%h",
                              got.status, got.room, got.average, got.held, got.hot,
                              got.cold, got.stamp);
               end
            end
         end
         if (quiet_cycles >= 5000) begin
            $display("per_sensor_moving_average_alarm_tb: done, errors");
            $finish;
         end
      end
   end

   function automatic reading_type make_reading(psma_pkg::mode_type m, logic [15:0] sid,
                                                logic [15:0] rid, logic [15:0] val,
                                                logic [31:0] ts);
      reading_type r;
      r.mode = m;
      r.node_id = sid;
      r.room_id = rid;
      r.sample_value = val;
      r.sample_time = ts;
      return r;
   endfunction

   task automatic load_sensor(logic [15:0] sid, logic [15:0] rid);
      pending_readings.push_back(make_reading(psma_pkg::MODE_LOAD, sid, rid, 16'($urandom),
                                              $urandom));
      known_ids.push_back(sid);
   endtask

   task automatic send_sample(logic [15:0] sid, logic [15:0] val, logic [31:0] ts);
      pending_readings.push_back(make_reading(psma_pkg::MODE_SAMPLE, sid, 16'($urandom), val,
                                              ts));
   endtask

   task automatic wait_idle();
      while (pending_readings.size() > 0 || req_tvalid || expected_reports.size() > 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_limits(logic [15:0] hot_v, logic [15:0] cold_v);
      csr_we <= 1'b1;
      csr_index <= psma_pkg::REG_MAX_TEMP;
      csr_wdata <= hot_v;
      hot_limit = $signed(hot_v);
      @(negedge clock);
      csr_index <= psma_pkg::REG_MIN_TEMP;
      csr_wdata <= cold_v;
      cold_limit = $signed(cold_v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // random traffic: mostly samples to loaded sensors, some loads, noise and bad values
   task automatic random_phase(int count);
      int          pick;
      logic [15:0] sid;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         sid = known_ids[$urandom_range(0, known_ids.size() - 1)];
         if (pick < 6) begin
            load_sensor(($urandom_range(0, 3) == 0) ? sid : 16'($urandom), 16'($urandom));
         end else if (pick < 14) begin
            send_sample(16'($urandom), 16'($urandom_range(1, 32767)), $urandom);
         end else if (pick < 24) begin
            send_sample(sid, 16'(-$urandom_range(0, 32768)), $urandom);
         end else if (pick < 60) begin
            send_sample(sid, 16'($urandom_range(1500, 7500)), $urandom);
         end else begin
            send_sample(sid, 16'($urandom_range(1, 32767)), $urandom);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      entries = 0;
      hot_limit = 6400;
      cold_limit = 2560;
      mismatches = 0;
      quiet_cycles = 0;
      req_gap = 0;
      rsp_stall = 0;
      req_taken = 1'b0;
      no_idle = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: extreme ids, a duplicate id, invalid and extreme samples, saturation
      load_sensor(16'h0000, 16'h0001);
      load_sensor(16'hFFFF, 16'hFFFF);
      load_sensor(16'h1234, 16'h0000);
      load_sensor(16'h1234, 16'hABCD);
      load_sensor(16'h8001, 16'h7FFE);
      send_sample(16'h1234, 16'h0000, 32'h1);
      send_sample(16'h5555, 16'h0100, 32'h2);
      send_sample(16'h1234, 16'h8000, 32'h3);
      send_sample(16'h1234, 16'h7FFF, 32'hFFFF_FFFF);
      send_sample(16'h1234, 16'h0001, 32'h0);
      send_sample(16'h0000, 16'h0064, 32'h5);
      send_sample(16'hFFFF, 16'hFFFF, 32'h6);
      send_sample(16'hFFFF, 16'd6400, 32'h7);
      send_sample(16'hFFFF, 16'd6399, 32'h8);
      send_sample(16'hFFFF, 16'd2559, 32'h9);
      send_sample(16'hFFFF, 16'd2560, 32'hA);
      send_sample(16'hFFFF, 16'h7FFF, 32'hB);
      send_sample(16'hFFFF, 16'h7FFF, 32'hC);
      send_sample(16'hFFFF, 16'h7FFF, 32'hD);
      send_sample(16'h8001, 16'hFFFF, 32'hE);
      wait_idle();

      // fill the table, then run traffic under several threshold settings
      write_limits(16'h7FFF, 16'h8000);
      for (int k = 0; k < 11; k++)
         load_sensor(($urandom_range(0, 3) == 0) ? known_ids[$urandom_range(0, 4)]
                                                 : 16'($urandom), 16'($urandom));
      load_sensor(16'($urandom), 16'($urandom));
      random_phase(140);
      wait_idle();
      write_limits(16'h8000, 16'h7FFF);
      no_idle = 1'b1;
      random_phase(150);
      wait_idle();
      no_idle = 1'b0;
      write_limits(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)));
      random_phase(150);
      wait_idle();
      write_limits(16'd6400, 16'd2560);
      random_phase(150);
      wait_idle();
      repeat (30) @(negedge clock);

      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("per_sensor_moving_average_alarm_tb: done, clean");
      end else begin
         $display("per_sensor_moving_average_alarm_tb: done, errors");
      end
      $finish;
   end

endmodule
